>>> rtl/block_bitmap_allocator_top_assert.svh
// Assertion macros for the allocator RTL.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bba_pkg.sv
package bba_pkg;

  // Width of the block number and free count fields
  localparam int unsigned FIELD_W      = 14;
  // Default bitmap size in blocks
  localparam int unsigned MAP_BITS_DEF = 8192;
  // Bitmap memory word
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned POS_W        = 5;
  // Limit register value after reset
  localparam logic [FIELD_W-1:0] LIMIT_RST = 14'd8192;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic free_rd;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_err;
    logic scan_done;
    logic slot_free;
  } sts_t;

endpackage

>>> rtl/bba_req_if.sv
interface bba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bba_pkg::FIELD_W-1:0]   block_number;

  modport source (output valid, output op, output block_number, input ready);
  modport sink (input valid, input op, input block_number, output ready);
endinterface

>>> rtl/bba_rsp_if.sv
interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::FIELD_W-1:0]   allocated_number;
  logic [1:0]                    status;
  logic [bba_pkg::FIELD_W-1:0]   free_count;

  modport source (output valid, output allocated_number, output status, output free_count,
                  input ready);
  modport sink (input valid, input allocated_number, input status, input free_count,
                output ready);
endinterface

>>> rtl/block_bitmap_allocator_top.sv
// Allocate: scans 32-bit bitmap words (up to 256) until a free bit or the limit.
// Free: reads and checks the block's word; an out-of-range number skips the read.
// One request in flight; the next is accepted the cycle after a result is registered.
// The scan reads one bitmap memory word per cycle through a single read port.
// Reset: limit returns to 8192, no blocks in use; untouched words read as free via a
// high-water word count, so no clearing pass is needed and requests are taken at once.
module block_bitmap_allocator_top #(
  parameter int unsigned MAP_BITS = bba_pkg::MAP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::FIELD_W-1:0] cfg_wdata_i,
  bba_req_if.sink                     req,
  bba_rsp_if.source                   rsp
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_op_i    (req.op),
    .sts_i      (sts),
    .in_ready_o (req.ready),
    .cmd_o      (cmd)
  );

  // Bitmap, counters and result register
  bba_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (req.op),
    .in_num_i     (req.block_number),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (rsp.ready),
    .out_valid_o  (rsp.valid),
    .out_num_o    (rsp.allocated_number),
    .out_status_o (rsp.status),
    .out_free_o   (rsp.free_count)
  );

endmodule

>>> rtl/bba_ctrl.sv
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  input  bba_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output bba_pkg::cmd_t cmd_o
);

  bba_pkg::state_e state_q, state_d;

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (bba_pkg::op_e'(in_op_i) == bba_pkg::OP_FREE) ? bba_pkg::S_FREE_RD
                                                                   : bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        if (sts_i.scan_done && sts_i.slot_free) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_FREE_RD: begin
        if (!sts_i.range_err) begin
          state_d = bba_pkg::S_FREE_CHK;
        end else if (sts_i.slot_free) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        if (sts_i.slot_free) state_d = bba_pkg::S_IDLE;
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      bba_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bba_pkg::S_SCAN: begin
        cmd_o.scan_rd = !sts_i.scan_done;
        cmd_o.commit  = sts_i.scan_done && sts_i.slot_free;
      end
      bba_pkg::S_FREE_RD: begin
        cmd_o.free_rd = !sts_i.range_err;
        cmd_o.commit  = sts_i.range_err && sts_i.slot_free;
      end
      bba_pkg::S_FREE_CHK: begin
        cmd_o.commit = sts_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/bba_dp.sv
`include "block_bitmap_allocator_top_assert.svh"

module bba_dp #(
  parameter int unsigned MAP_BITS = bba_pkg::MAP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                        in_op_i,
  input  logic [bba_pkg::FIELD_W-1:0] in_num_i,
  input  bba_pkg::cmd_t               cmd_i,
  output bba_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [bba_pkg::FIELD_W-1:0] out_num_o,
  output logic [1:0]                  out_status_o,
  output logic [bba_pkg::FIELD_W-1:0] out_free_o
);

  localparam int unsigned WB        = bba_pkg::WORD_BITS;
  localparam int unsigned PW        = bba_pkg::POS_W;
  localparam int unsigned FW        = bba_pkg::FIELD_W;
  localparam int unsigned MAP_WORDS = (MAP_BITS + WB - 1) / WB;
  localparam int unsigned IDX_W     = $clog2(MAP_BITS);
  localparam int unsigned CNT_W     = $clog2(MAP_BITS + 1);
  localparam int unsigned WORD_W    = $clog2(MAP_WORDS);
  localparam int unsigned HWM_W     = $clog2(MAP_WORDS + 1);
  localparam int unsigned BASE_W    = WORD_W + PW;
  localparam int unsigned LW        = (CNT_W > FW) ? CNT_W : FW;
  localparam int unsigned SW        = ((CNT_W > BASE_W) ? CNT_W : BASE_W) + 1;

  // Bitmap memory and its read register
  logic [WB-1:0]     mem_q [MAP_WORDS];
  logic [WB-1:0]     rdata_q;
  logic [WORD_W-1:0] rd_word_q;
  logic              data_vld_q;

  logic [FW-1:0]     limit_q;
  bba_pkg::op_e      op_q;
  logic [FW-1:0]     num_q;
  logic [WORD_W-1:0] scan_addr_q;
  logic [HWM_W-1:0]  hwm_q;
  logic [CNT_W-1:0]  used_q, used_d;

  logic              out_valid_q;
  logic [FW-1:0]     out_num_q;
  bba_pkg::status_e  out_st_q;
  logic [FW-1:0]     out_free_q;

  logic [CNT_W-1:0]  lim;
  logic              range_err;
  logic [IDX_W-1:0]  fidx;
  logic              rd_en;
  logic [WORD_W-1:0] rd_addr;
  logic [WB-1:0]     word_eff;
  logic [BASE_W-1:0] base;
  logic [SW-1:0]     lim_x, base_x, diff;
  logic [WB-1:0]     keep;
  logic              last_word;
  logic [WB-1:0]     avail;
  logic              found;
  logic [PW-1:0]     pos;
  logic              fbit;
  logic              slot_free;
  logic              wr_en;
  logic [WORD_W-1:0] wr_addr;
  logic [WB-1:0]     wr_data;
  logic [FW-1:0]     res_num;
  bba_pkg::status_e  res_st;
  logic [CNT_W-1:0]  res_free;

  // Effective limit, saturated to the bitmap size
  assign lim = (LW'(limit_q) > LW'(MAP_BITS)) ? CNT_W'(MAP_BITS) : CNT_W'(limit_q);

  // Free request decode
  assign range_err = (num_q == '0) || (LW'(num_q) > LW'(lim));
  assign fidx      = IDX_W'(num_q - FW'(1));

  // Read address: scan pointer or word of the block to free
  assign rd_en   = cmd_i.scan_rd || cmd_i.free_rd;
  assign rd_addr = cmd_i.free_rd ? WORD_W'(fidx >> PW) : scan_addr_q;

  // Words at or above the high-water mark were never written and read as free
  assign word_eff = (HWM_W'(rd_word_q) < hwm_q) ? rdata_q : '0;

  // Mask off bits at or above the limit within the current word
  assign base   = {rd_word_q, PW'(0)};
  assign lim_x  = SW'(lim);
  assign base_x = SW'(base);
  assign diff   = lim_x - base_x;
  always_comb begin
    if (lim_x <= base_x) begin
      keep      = '0;
      last_word = 1'b1;
    end else if (diff >= SW'(WB)) begin
      keep      = '1;
      last_word = (diff == SW'(WB));
    end else begin
      keep      = ~({WB{1'b1}} << diff[PW-1:0]);
      last_word = 1'b1;
    end
  end

  // Lowest free bit of the word
  assign avail = ~word_eff & keep;
  assign found = |avail;
  always_comb begin
    pos = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (avail[j]) pos = PW'(j);
    end
  end

  assign fbit      = word_eff[fidx[PW-1:0]];
  assign slot_free = !out_valid_q || out_ready_i;

  assign sts_o.range_err = range_err;
  assign sts_o.scan_done = data_vld_q && (found || last_word);
  assign sts_o.slot_free = slot_free;

  // Result and bitmap update for the request being finished
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_word_q;
    wr_data = word_eff;
    used_d  = used_q;
    res_num = '0;
    res_st  = bba_pkg::ST_OK;
    if (op_q == bba_pkg::OP_ALLOC) begin
      if (found) begin
        wr_en   = cmd_i.commit;
        wr_data = word_eff | (WB'(1) << pos);
        used_d  = used_q + CNT_W'(1);
        res_num = FW'(CNT_W'(base) + CNT_W'(pos) + CNT_W'(1));
      end else begin
        res_st = bba_pkg::ST_FULL;
      end
    end else begin
      if (range_err) begin
        res_st = bba_pkg::ST_RANGE;
      end else if (!fbit) begin
        res_st = bba_pkg::ST_ALREADY_FREE;
      end else begin
        wr_en   = cmd_i.commit;
        wr_data = word_eff & ~(WB'(1) << fidx[PW-1:0]);
        used_d  = (used_q != '0) ? used_q - CNT_W'(1) : used_q;
      end
    end
    res_free = (lim > used_d) ? lim - used_d : '0;
  end

  // Bitmap memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q   <= mem_q[rd_addr];
      rd_word_q <= rd_addr;
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= bba_pkg::op_e'(in_op_i);
      num_q <= in_num_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_num_q  <= res_num;
      out_st_q   <= res_st;
      out_free_q <= FW'(res_free);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= bba_pkg::LIMIT_RST;
      scan_addr_q <= '0;
      data_vld_q  <= 1'b0;
      hwm_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      // Restart the scan on each new request, step it on each scan read
      if (cmd_i.accept) begin
        scan_addr_q <= '0;
        data_vld_q  <= 1'b0;
      end else if (rd_en) begin
        data_vld_q <= 1'b1;
        if (cmd_i.scan_rd) scan_addr_q <= scan_addr_q + WORD_W'(1);
      end
      // Extend the high-water mark when a fresh word is written
      if (wr_en && (HWM_W'(wr_addr) == hwm_q)) hwm_q <= hwm_q + HWM_W'(1);
      if (cmd_i.commit) used_q <= used_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_num_o    = out_num_q;
  assign out_status_o = out_st_q;
  assign out_free_o   = out_free_q;

  `BBA_ASSERT_IMP(a_commit_slot, clk_i, rst_ni, cmd_i.commit, slot_free, "result slot overrun")
  `BBA_ASSERT_IMP(a_wr_hwm, clk_i, rst_ni, wr_en, HWM_W'(wr_addr) <= hwm_q, "write past mark")
  `BBA_ASSERT_NXT(a_alloc_cnt, clk_i, rst_ni, wr_en && (op_q == bba_pkg::OP_ALLOC), (used_q - $past(used_q)) == CNT_W'(1), "alloc count slip")
  `BBA_ASSERT_NXT(a_out_load, clk_i, rst_ni, cmd_i.commit, out_valid_q, "result not loaded")

endmodule
